// ===== rtl/sitpd_pkg.sv =====
// ----------------------------------------------------------------------------
// sitpd_pkg
// Shared constants for the signed integer to padded decimal text converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sitpd_pkg;

  // Fixed sizes of the number and of the field
  localparam int VALUE_BITS = 32;
  localparam int MAX_WIDTH  = 64;
  localparam int MINW_BITS  = 7;

  // Decimal digits that hold the magnitude 2**(VALUE_BITS-1); may overshoot by one
  localparam int NDIG  = ((VALUE_BITS - 1) * 302) / 1000 + 1;
  localparam int BCD_W = NDIG * 4;
  localparam int DIG_W = $clog2(NDIG + 1);
  localparam int CNT_W = ($clog2(MAX_WIDTH + 1) > MINW_BITS) ?
                         $clog2(MAX_WIDTH + 1) : MINW_BITS;
  localparam int BIT_W = $clog2(VALUE_BITS);

  // ASCII codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef logic [BCD_W-1:0]      bcd_t;
  typedef logic [VALUE_BITS-1:0] mag_t;
  typedef logic [CNT_W-1:0]      cnt_t;

endpackage

`default_nettype wire

// ===== rtl/signed_int_to_padded_decimal.sv =====
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal
// Converts a signed integer to right-aligned decimal ASCII text, one
// character per output transaction, padded with spaces to a minimum width.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_value[31:0], in_min_width[6:0]
// out      output     out_valid/out_stall out_ch[7:0], out_last
//
// Each transaction: an accept step, VALUE_BITS (32) shift-and-add-3 steps,
// then 0 to NDIG-1 (9) leading-zero shifts and a step that sets the
// padding, then one character per cycle while out_stall is low, in all
// max(min_width saturated to MAX_WIDTH, text length) characters. The shared
// BCD shift unit sets the conversion time, the output port the emission time.
// Reset is synchronous; in_stall is high whenever a value is in progress.
// out_stall only holds the output register and delays the next character.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_padded_decimal
  import sitpd_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic signed [VALUE_BITS-1:0] in_value,
  input  wire logic        [MINW_BITS-1:0]  in_min_width,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic             [7:0]            out_ch,
  output logic                              out_last
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CONV  = 3'd1;
  localparam logic [2:0] ST_NORM  = 3'd2;
  localparam logic [2:0] ST_PAD   = 3'd3;
  localparam logic [2:0] ST_SIGN  = 3'd4;
  localparam logic [2:0] ST_DIGIT = 3'd5;

  logic [2:0]       state_r, state_nxt;
  mag_t             mag_r, mag_nxt;
  bcd_t             bcd_r, bcd_nxt;
  logic             neg_r, neg_nxt;
  cnt_t             width_r, width_nxt;
  cnt_t             pad_r, pad_nxt;
  logic [DIG_W-1:0] ndig_r, ndig_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_ch_r, out_ch_nxt;
  logic             out_last_r, out_last_nxt;

  logic             slot_free;
  bcd_t             bcd_adj;
  logic [3:0]       top_dig;
  cnt_t             text_len;
  cnt_t             pad_calc;
  cnt_t             width_in;

  // Add 3 to every digit of 5 or more ahead of the shift
  function automatic bcd_t add3(input bcd_t b);
    bcd_t r;
    r = b;
    for (int i = 0; i < NDIG; i++) begin
      if (r[i*4 +: 4] >= 4'd5) begin
        r[i*4 +: 4] = r[i*4 +: 4] + 4'd3;
      end
    end
    return r;
  endfunction

  assign slot_free = !out_valid_r || !out_stall;
  assign bcd_adj   = add3(bcd_r);
  assign top_dig   = bcd_r[BCD_W-1 -: 4];
  assign text_len  = CNT_W'(ndig_r) + CNT_W'(neg_r);
  assign pad_calc  = (width_r > text_len) ? (width_r - text_len) : '0;
  assign width_in  = (CNT_W'(in_min_width) > CNT_W'(MAX_WIDTH)) ?
                     CNT_W'(MAX_WIDTH) : CNT_W'(in_min_width);

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    neg_nxt       = neg_r;
    width_nxt     = width_r;
    pad_nxt       = pad_r;
    ndig_nxt      = ndig_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_ch_nxt    = out_ch_r;
    out_last_nxt  = out_last_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          neg_nxt   = in_value[VALUE_BITS-1];
          mag_nxt   = in_value[VALUE_BITS-1] ? mag_t'(-in_value) : mag_t'(in_value);
          bcd_nxt   = '0;
          width_nxt = width_in;
          ndig_nxt  = DIG_W'(NDIG);
          bit_nxt   = BIT_W'(VALUE_BITS - 1);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
        mag_nxt = {mag_r[VALUE_BITS-2:0], 1'b0};
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          state_nxt = ST_NORM;
        end
      end
      ST_NORM: begin
        // drop leading zero digits, keep at least one
        if (ndig_r > DIG_W'(1) && top_dig == 4'd0) begin
          bcd_nxt  = {bcd_r[BCD_W-5:0], 4'd0};
          ndig_nxt = ndig_r - 1'b1;
        end else begin
          pad_nxt = pad_calc;
          if (pad_calc != '0) begin
            state_nxt = ST_PAD;
          end else if (neg_r) begin
            state_nxt = ST_SIGN;
          end else begin
            state_nxt = ST_DIGIT;
          end
        end
      end
      ST_PAD: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = CH_SPACE;
          out_last_nxt  = 1'b0;
          pad_nxt       = pad_r - 1'b1;
          if (pad_r == cnt_t'(1)) begin
            state_nxt = neg_r ? ST_SIGN : ST_DIGIT;
          end
        end
      end
      ST_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = CH_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_ch_nxt    = CH_ZERO + {4'd0, top_dig};
          out_last_nxt  = (ndig_r == DIG_W'(1));
          bcd_nxt       = {bcd_r[BCD_W-5:0], 4'd0};
          ndig_nxt      = ndig_r - 1'b1;
          if (ndig_r == DIG_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r      <= mag_nxt;
    bcd_r      <= bcd_nxt;
    neg_r      <= neg_nxt;
    width_r    <= width_nxt;
    pad_r      <= pad_nxt;
    ndig_r     <= ndig_nxt;
    bit_r      <= bit_nxt;
    out_ch_r   <= out_ch_nxt;
    out_last_r <= out_last_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_ch    = out_ch_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire
